// ===== sv/nlcb_pkg.sv =====
// ----------------------------------------------------------------------------
// nlcb_pkg
// Shared types and constants for the non-zero lane compaction buffer.
// ----------------------------------------------------------------------------
package nlcb_pkg;

    localparam int LANES   = 4;
    localparam int ELEM_W  = 64;
    localparam int HOLD    = LANES - 1;          // held elements at most
    localparam int POOL    = 2 * LANES - 1;      // held plus new, worst case
    localparam int CNT_W   = $clog2(LANES + 1);  // result count width
    localparam int HCNT_W  = $clog2(LANES);      // held count width
    localparam int SLOT_W  = $clog2(POOL + 1);   // pool index / total width

    typedef logic [ELEM_W-1:0] elem_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [HCNT_W-1:0] hcnt_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic
    {
        REQ_SERVE = 1'b0,
        REQ_FLUSH = 1'b1
    } req_t;

    // what one lane reports to the merge stage
    typedef struct packed
    {
        logic  keep;
        slot_t slot;
    } lane_res_t;

    typedef struct packed
    {
        elem_t [LANES-1:0] elems;
        cnt_t              count;
    } result_t;

endpackage

// ===== sv/nlcb_lane.sv =====
// ----------------------------------------------------------------------------
// nlcb_lane
// One input lane: zero test and placement of the element in the merge pool.
// ----------------------------------------------------------------------------
module nlcb_lane
(
    input  nlcb_pkg::elem_t     elem,
    input  nlcb_pkg::slot_t     base_in,
    output nlcb_pkg::lane_res_t res,
    output nlcb_pkg::slot_t     base_out
);
    import nlcb_pkg::*;

    logic nonzero;

    assign nonzero   = (elem != '0);
    assign res.keep  = nonzero;
    assign res.slot  = base_in;
    // next free pool slot for the lanes after this one
    assign base_out  = base_in + slot_t'(nonzero);

endmodule

// ===== sv/nlcb_merge.sv =====
// ----------------------------------------------------------------------------
// nlcb_merge
// Combines held elements and kept lanes into the result and the next store.
// ----------------------------------------------------------------------------
module nlcb_merge
(
    input  logic                                  flush,
    input  nlcb_pkg::elem_t [nlcb_pkg::HOLD-1:0]  held,
    input  nlcb_pkg::hcnt_t                       hcount,
    input  nlcb_pkg::elem_t [nlcb_pkg::LANES-1:0] elems,
    input  nlcb_pkg::lane_res_t [nlcb_pkg::LANES-1:0] lanes,
    input  nlcb_pkg::slot_t                       total,
    output nlcb_pkg::result_t                     result,
    output nlcb_pkg::elem_t [nlcb_pkg::HOLD-1:0]  held_next,
    output nlcb_pkg::hcnt_t                       hcount_next
);
    import nlcb_pkg::*;

    elem_t [POOL-1:0] pool;
    logic             full;

    // held entries above the count are zero, so they OR in harmlessly
    always_comb
    begin
        pool = '0;
        for (int k = 0; k < HOLD; k++)
        begin
            pool[k] = held[k];
        end
        for (int k = 0; k < POOL; k++)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (lanes[i].keep && (lanes[i].slot == slot_t'(k)))
                begin
                    pool[k] = pool[k] | elems[i];
                end
            end
        end
    end

    assign full = (total >= slot_t'(LANES));

    always_comb
    begin
        result.elems = '0;
        result.count = '0;
        held_next    = '0;
        hcount_next  = '0;
        if (flush)
        begin
            for (int k = 0; k < HOLD; k++)
            begin
                result.elems[k] = held[k];
            end
            result.count = cnt_t'(hcount);
        end
        else if (full)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                result.elems[k] = pool[k];
            end
            result.count = cnt_t'(LANES);
            for (int k = 0; k < HOLD; k++)
            begin
                held_next[k] = pool[LANES + k];
            end
            hcount_next = hcnt_t'(total - slot_t'(LANES));
        end
        else
        begin
            for (int k = 0; k < HOLD; k++)
            begin
                held_next[k] = pool[k];
            end
            hcount_next = hcnt_t'(total);
        end
    end

endmodule

// ===== sv/nonzero_lane_compaction_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// nonzero_lane_compaction_buffer_unit
// Four-lane non-zero stream compaction with held remainder and flush.
// ----------------------------------------------------------------------------
// Every transfer in yields one transfer out. A serve drops zero lanes, appends
// the rest after up to three held elements and emits the oldest four (count 4)
// once four are available, else count 0; a flush emits the held elements and
// empties the store. Throughput is one item per cycle while in_stall is low:
// four lanes test and place their elements in parallel and one merge stage
// builds the result, registered in the output register or, behind a stalled
// output register, in the skid register. This two-entry output buffer keeps
// in_stall registered; it rises only once two results are waiting.
// ----------------------------------------------------------------------------
module nonzero_lane_compaction_buffer_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  nlcb_pkg::elem_t       in_elem0,
    input  nlcb_pkg::elem_t       in_elem1,
    input  nlcb_pkg::elem_t       in_elem2,
    input  nlcb_pkg::elem_t       in_elem3,
    output logic                  out_valid,
    input  logic                  out_stall,
    output nlcb_pkg::elem_t       out_elem0,
    output nlcb_pkg::elem_t       out_elem1,
    output nlcb_pkg::elem_t       out_elem2,
    output nlcb_pkg::elem_t       out_elem3,
    output nlcb_pkg::cnt_t        out_count
);
    import nlcb_pkg::*;

    elem_t [HOLD-1:0]  held_reg;
    elem_t [HOLD-1:0]  held_next;
    hcnt_t             hcount_reg;
    hcnt_t             hcount_next;

    result_t           out_reg;
    logic              out_valid_reg;
    result_t           skid_reg;
    logic              skid_valid_reg;

    elem_t [LANES-1:0]     elems;
    lane_res_t [LANES-1:0] lanes;
    slot_t [LANES:0]       base;
    result_t               result;
    logic                  accept_in;
    logic                  out_free;
    logic                  flush;

    assign elems[0] = in_elem0;
    assign elems[1] = in_elem1;
    assign elems[2] = in_elem2;
    assign elems[3] = in_elem3;

    assign flush = (req_t'(req_type) == REQ_FLUSH);

    // placement chain starts after the held elements
    assign base[0] = slot_t'(hcount_reg);

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        nlcb_lane u_lane
        (
            .elem     (elems[g]),
            .base_in  (base[g]),
            .res      (lanes[g]),
            .base_out (base[g+1])
        );
    end

    nlcb_merge u_merge
    (
        .flush       (flush),
        .held        (held_reg),
        .hcount      (hcount_reg),
        .elems       (elems),
        .lanes       (lanes),
        .total       (base[LANES]),
        .result      (result),
        .held_next   (held_next),
        .hcount_next (hcount_next)
    );

    assign in_stall  = skid_valid_reg;
    assign accept_in = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            hcount_reg <= '0;
        end
        else if (accept_in)
        begin
            held_reg   <= held_next;
            hcount_reg <= hcount_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg || accept_in;
                skid_valid_reg <= 1'b0;
            end
            else if (accept_in)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept_in)
            begin
                out_reg <= result;
            end
        end
        else if (accept_in)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_elem0 = out_reg.elems[0];
    assign out_elem1 = out_reg.elems[1];
    assign out_elem2 = out_reg.elems[2];
    assign out_elem3 = out_reg.elems[3];
    assign out_count = out_reg.count;

`ifndef SYNTHESIS
    // skid entry only fills behind a stalled output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // held entries above the count stay zero
    a_held_zero_tail: assert property (@(posedge clk) disable iff (!rst_n)
        ((hcount_reg != 2'd0) || (held_reg[0] == '0)) &&
        ((hcount_reg >= 2'd2) || (held_reg[1] == '0)) &&
        ((hcount_reg == 2'd3) || (held_reg[2] == '0)))
        else $error("stale held element above count");

    // a flush leaves the store empty
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && flush) |=> (hcount_reg == '0))
        else $error("store not empty after flush");

    // a serve result carries either nothing or a full vector
    a_serve_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && !flush) |->
            (result.count == '0 || result.count == cnt_t'(LANES)))
        else $error("partial count on serve");

    // every accepted item produces an output entry next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> out_valid_reg)
        else $error("accepted item lost");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the four-lane non-zero compaction buffer. A directed run of
// flushes, all-zero, partial and full vectors is followed by about a thousand
// random items. Both sides idle and stall at random, and the receiver holds
// off for long stretches so that the block backs up. A scoreboard predicts
// every result and compares it field by field as it comes out.
// ----------------------------------------------------------------------------
module tb_top;

    import nlcb_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int RAND_ITEMS  = 1000;
    localparam int DRAIN_WAIT  = 10;
    localparam int REPORT_MAX  = 10;

    typedef struct
    {
        elem_t lane [LANES];
        cnt_t  count;
    } packed_vec_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the held elements and predicts the
    // packed vector for every accepted transfer.
    // ------------------------------------------------------------------------
    class compaction_scoreboard;
        elem_t         held [HOLD];
        int unsigned   held_cnt;
        packed_vec_t   pending [$];
        int unsigned   mismatches;

        function new();
            foreach (held[i])
                held[i] = '0;
            held_cnt   = 0;
            mismatches = 0;
        endfunction

        function void note_input(req_t req, elem_t lanes [LANES]);
            packed_vec_t want;
            elem_t       pool [2*LANES];
            int unsigned total;
            foreach (want.lane[i])
                want.lane[i] = '0;
            want.count = '0;
            total = 0;
            if (req == REQ_FLUSH)
            begin
                for (int i = 0; i < held_cnt; i++)
                    want.lane[i] = held[i];
                want.count = cnt_t'(held_cnt);
                held_cnt   = 0;
            end
            else
            begin
                for (int i = 0; i < held_cnt; i++)
                    pool[total++] = held[i];
                for (int i = 0; i < LANES; i++)
                    if (lanes[i] != '0)
                        pool[total++] = lanes[i];
                if (total >= LANES)
                begin
                    for (int i = 0; i < LANES; i++)
                        want.lane[i] = pool[i];
                    want.count = cnt_t'(LANES);
                    held_cnt   = total - LANES;
                    for (int i = 0; i < held_cnt; i++)
                        held[i] = pool[LANES + i];
                end
                else
                begin
                    held_cnt = total;
                    for (int i = 0; i < total; i++)
                        held[i] = pool[i];
                end
            end
            // entries above the held count stay zero
            for (int i = held_cnt; i < HOLD; i++)
                held[i] = '0;
            pending.push_back(want);
        endfunction

        function void report(string field, elem_t want, elem_t got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("[%0t] mismatch on %s: expected %h, got %h",
                         $time, field, want, got);
        endfunction

        function void check_result(elem_t got [LANES], cnt_t cnt);
            packed_vec_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] result transfer with nothing expected, count %0d",
                             $time, cnt);
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < LANES; i++)
                if (got[i] !== want.lane[i])
                    report($sformatf("out_elem%0d", i), want.lane[i], got[i]);
            if (cnt !== want.count)
                report("out_count", elem_t'(want.count), elem_t'(cnt));
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    logic   req_type;
    elem_t  in_elem0;
    elem_t  in_elem1;
    elem_t  in_elem2;
    elem_t  in_elem3;
    logic   out_valid;
    logic   out_stall;
    elem_t  out_elem0;
    elem_t  out_elem1;
    elem_t  out_elem2;
    elem_t  out_elem3;
    cnt_t   out_count;

    compaction_scoreboard sb = new();
    int unsigned item_idx;
    int unsigned rx_count;
    int unsigned idle_cycles;

    nonzero_lane_compaction_buffer_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .in_elem0  (in_elem0),
        .in_elem1  (in_elem1),
        .in_elem2  (in_elem2),
        .in_elem3  (in_elem3),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_elem0 (out_elem0),
        .out_elem1 (out_elem1),
        .out_elem2 (out_elem2),
        .out_elem3 (out_elem3),
        .out_count (out_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitors and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : input_monitor
        elem_t lanes [LANES];
        if (rst_n && in_valid && !in_stall)
        begin
            lanes[0] = in_elem0;
            lanes[1] = in_elem1;
            lanes[2] = in_elem2;
            lanes[3] = in_elem3;
            sb.note_input(req_t'(req_type), lanes);
        end
    end

    always @(posedge clk)
    begin : output_monitor
        elem_t lanes [LANES];
        if (rst_n && out_valid && !out_stall)
        begin
            lanes[0] = out_elem0;
            lanes[1] = out_elem1;
            lanes[2] = out_elem2;
            lanes[3] = out_elem3;
            sb.check_result(lanes, out_count);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall per result, quiet stretches, and two long
    // hold-offs that back the block up into its input.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned hold;
        out_stall = 1'b0;
        rx_count  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_count == 150 || rx_count == 700)
                hold = $urandom_range(50, 90);
            else if ((rx_count / 80) % 4 == 2)
                hold = 0;
            else
                hold = $urandom_range(0, 5);
            if (hold > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            rx_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_item(req_t req, elem_t e0, elem_t e1, elem_t e2, elem_t e3);
        int unsigned gap;
        gap = ((item_idx / 64) % 4 == 1) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_type <= req;
        in_elem0 <= e0;
        in_elem1 <= e1;
        in_elem2 <= e2;
        in_elem3 <= e3;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        item_idx++;
    endtask

    // mostly zero lanes or full random words, with the corners mixed in
    function automatic elem_t rand_lane();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: return '0;
            4:          return '1;
            5:          return elem_t'(1) << $urandom_range(0, ELEM_W - 1);
            6:          return elem_t'($urandom_range(1, 255));
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin : stimulus
        req_t req;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_SERVE;
        in_elem0 = '0;
        in_elem1 = '0;
        in_elem2 = '0;
        in_elem3 = '0;
        item_idx = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed corners
        send_item(REQ_FLUSH, '0, '0, '0, '0);                  // flush, nothing held
        send_item(REQ_SERVE, '0, '0, '0, '0);                  // all lanes zero, empty
        send_item(REQ_SERVE, '1, '1, '1, '1);                  // exactly four
        send_item(REQ_SERVE, '0, '0, '0, 64'd1);               // hold one
        send_item(REQ_SERVE, '0, '0, '0, '0);                  // all zero, held kept
        send_item(REQ_SERVE, 64'h8000_0000_0000_0000, '0,
                  64'h5555_5555_5555_5555, '0);                // hold three
        send_item(REQ_SERVE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h2,
                  64'h3, '1);                                  // seven: emit four, hold three
        send_item(REQ_FLUSH, '1, '1, '1, '1);                  // flush three, lanes ignored
        send_item(REQ_FLUSH, '0, '0, '0, '0);                  // flush empty again
        send_item(REQ_SERVE, 64'h11, 64'h22, 64'h33, '0);      // hold three
        send_item(REQ_SERVE, '0, 64'h44, '0, '0);              // exactly four with held
        send_item(REQ_SERVE, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_item(REQ_FLUSH, '0, '0, '0, '0);                  // flush one
        send_item(REQ_SERVE, 64'h5555_5555_5555_5555, '0, '0,
                  64'hAAAA_AAAA_AAAA_AAAA);
        send_item(REQ_FLUSH, 64'h1, '0, '0, '0);               // flush two
        send_item(REQ_SERVE, '0, 64'hFF, 64'hFF00, 64'hFF_0000);
        send_item(REQ_SERVE, 64'h1, '0, '0, '0);               // exactly four
        send_item(REQ_SERVE, '1, '0, '1, '1);                  // hold three
        send_item(REQ_SERVE, '1, '1, '0, '1);                  // six: emit four, hold two
        send_item(REQ_SERVE, '0, '0, '0, '0);
        send_item(REQ_FLUSH, '0, '0, '0, '0);

        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            req = ($urandom_range(0, 9) == 0) ? REQ_FLUSH : REQ_SERVE;
            send_item(req, rand_lane(), rand_lane(), rand_lane(), rand_lane());
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("TEST PASSED");
        else
        begin
            if (sb.outstanding() != 0)
                $display("%0d results never arrived", sb.outstanding());
            $display("%0d mismatches", sb.mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
